FILE: rtl/core/slot_pool_value_store_assert.svh
// assertion macros for the slot pool value store
`ifndef SLOT_POOL_VALUE_STORE_ASSERT_SVH
`define SLOT_POOL_VALUE_STORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SPVS_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that forces a consequence in the next cycle
`define SPVS_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: rtl/core/spvs_pkg.sv
// shared types and constants for the slot pool value store
`timescale 1ns / 1ps

package spvs_pkg;

    localparam int SLOTS  = 128;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = 7;
    localparam int VAL_W  = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } res_t;

    // search token walking down the row of slot cells
    typedef struct packed {
        logic                    active;
        logic [1:0]              action;
        logic signed [VAL_W-1:0] value;
        logic                    hit;
        logic [IDX_W-1:0]        idx;
    } token_t;

endpackage

FILE: rtl/core/spvs_cell.sv
// one slot of the pool: valid bit, stored value and one token stage
`timescale 1ns / 1ps

module spvs_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [spvs_pkg::IDX_W-1:0] cell_idx,
    input  spvs_pkg::token_t      tok_in,
    output spvs_pkg::token_t      tok_out
);
    import spvs_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [VAL_W-1:0] value_reg;
    token_t                  tok_reg;
    token_t                  tok_next;
    logic                    claim;
    logic                    match;

    // only the first cell that qualifies takes the token
    assign claim = tok_in.active && !tok_in.hit && (tok_in.action == ACT_INSERT)
                   && !valid_reg;
    assign match = tok_in.active && !tok_in.hit && valid_reg
                   && ((tok_in.action == ACT_REMOVE) || (tok_in.action == ACT_LOOKUP))
                   && (value_reg == tok_in.value);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        if (claim || match)
        begin
            tok_next.hit = 1'b1;
            tok_next.idx = cell_idx;
        end
        if (claim)
        begin
            valid_next = 1'b1;
        end
        else if (match && (tok_in.action == ACT_REMOVE))
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            value_reg <= tok_in.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/core/spvs_out_buf.sv
// two-entry result buffer between the cell row and the result channel
`timescale 1ns / 1ps

module spvs_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spvs_pkg::res_t  push_data,
    output logic            full,
    output logic            res_valid,
    input  logic            res_stall,
    output spvs_pkg::res_t  res
);
    import spvs_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;
    res_t out_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_reg;
    res_t skid_next;
    logic take;

    assign take = out_valid_reg && !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end
        else if (push)
        begin
            // output held by a stall, park the new result
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: rtl/core/slot_pool_value_store.sv
// top level of the slot pool value store
`timescale 1ns / 1ps

// A pool of SLOTS slots (128), each a cell holding a valid bit and a 32-bit
// value. Insert claims the lowest free slot, remove frees the lowest slot
// holding the value, lookup reports it; every transaction returns one result.
// An accepted command travels as a token through the row of cells, one cell
// per clock, and its result is pushed into the output buffer as the token
// leaves the last cell; the next command is taken only once the token has left
// the row, so only one transaction is in the row at a time. Up to two results
// wait on a stalled result channel before the command side stalls as well.
// Valid bits clear at reset, so the pool is usable right after reset with no
// clearing pass.

module slot_pool_value_store (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  spvs_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output spvs_pkg::res_t res
);
    import spvs_pkg::*;

    token_t chain_tok [SLOTS+1];
    logic   busy_reg;
    logic   busy_next;
    logic   accept;
    logic   buf_full;
    token_t tail;
    res_t   tail_res;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = busy_reg || buf_full;

    always_comb
    begin
        chain_tok[0]        = '0;
        chain_tok[0].active = accept;
        chain_tok[0].action = cmd.action;
        chain_tok[0].value  = cmd.value;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        spvs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_idx(IDX_W'(i)),
            .tok_in  (chain_tok[i]),
            .tok_out (chain_tok[i+1])
        );
    end

    assign tail = chain_tok[SLOTS];

    always_comb
    begin
        tail_res = '0;
        if (tail.hit)
        begin
            tail_res.status = ST_DONE;
            tail_res.slot   = SLOT_W'(tail.idx);
        end
        else if (tail.action == ACT_INSERT)
        begin
            tail_res.status = ST_FULL;
        end
        else
        begin
            tail_res.status = ST_NOT_FOUND;
        end
    end

    // busy while a token is inside the row
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.active)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    spvs_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (tail.active),
        .push_data(tail_res),
        .full     (buf_full),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

endmodule

FILE: rtl/core/spvs_checker.sv
// port-level checks for the slot pool value store, bound to the top level
`timescale 1ns / 1ps

`include "slot_pool_value_store_assert.svh"

module spvs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input spvs_pkg::cmd_t cmd,
    input logic           res_valid,
    input logic           res_stall,
    input spvs_pkg::res_t res
);
    import spvs_pkg::*;

    // a failed or unknown command never names a slot
    `SPVS_ASSERT_HOLDS(a_slot_zero_on_fail, !res_valid || (res.status == ST_DONE) || (res.slot == '0), "slot nonzero on failed result")

    // one command at a time: the row is busy right after a command is taken
    `SPVS_ASSERT_NEXT(a_stall_after_cmd, cmd_valid && !cmd_stall, cmd_stall, "command taken while row busy")

    `SPVS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

    `SPVS_ASSERT_NEXT(a_res_drop, res_valid && res_stall, res_valid, "result dropped while stalled")

endmodule

bind slot_pool_value_store spvs_checker u_checker (.*);
